[rtl/siol_pkg.sv]
// Package of shared constants, types and codes for the sector interleave order learner.
package siol_pkg;

  localparam int MaxSectors = 32;
  localparam int MaxTracks  = 1024;

  localparam int SecW    = $clog2(MaxSectors);
  localparam int CntW    = $clog2(MaxSectors + 1);
  localparam int SlotW   = $clog2(MaxTracks);
  localparam int TotW    = $clog2(MaxTracks + 1);
  localparam int RowAW   = SlotW + SecW;
  localparam int KeyW    = 16;
  localparam int IdW     = 8;
  localparam int CfgIdxW = 1;
  localparam int CfgW    = 8;
  localparam int SptW    = 6;

  localparam logic [SptW-1:0] SptReset = SptW'(17);

  localparam logic [1:0] OpHeader = 2'd0;
  localparam logic [1:0] OpFinish = 2'd1;
  localparam logic [1:0] OpLookup = 2'd2;

  localparam logic [1:0] OutDone  = 2'd0;
  localparam logic [1:0] OutRange = 2'd1;
  localparam logic [1:0] OutFull  = 2'd2;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_FIRST_SECTOR = 1'b0,
    CFG_TRACK_LEN    = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    CLS_HEADER,
    CLS_FINISH,
    CLS_LOOKUP,
    CLS_IGNORE
  } cls_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FIND,
    S_RANGE,
    S_REC,
    S_MLEN,
    S_MCNT,
    S_LOAD,
    S_BEST,
    S_INS,
    S_WB,
    S_LLEN,
    S_LCNT,
    S_LSRCH,
    S_RESP
  } state_e;

  typedef struct packed {
    cls_e             cls;
    logic [KeyW-1:0]  key;
    logic [IdW-1:0]   sid;
    logic [IdW-1:0]   fb;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } q_head_t;

  typedef struct packed {
    logic               we;
    logic [CfgIdxW-1:0] idx;
    logic [CfgW-1:0]    data;
  } cfg_wr_t;

endpackage

[rtl/siol_if.sv]
// Channel interfaces for input items and result items.
interface siol_item_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [11:0] cylinder;
  logic [3:0]  head;
  logic [7:0]  sec_num;
  logic [7:0]  fallback_position;

  modport source (output valid, operation, cylinder, head, sec_num, fallback_position,
                  input ready);
  modport sink (input valid, operation, cylinder, head, sec_num, fallback_position,
                output ready);
endinterface

interface siol_result_if;
  logic       valid;
  logic       ready;
  logic [9:0] track_slot;
  logic [7:0] position;
  logic       found;
  logic [1:0] outcome;

  modport source (output valid, track_slot, position, found, outcome, input ready);
  modport sink (input valid, track_slot, position, found, outcome, output ready);
endinterface

[rtl/siol_ram.sv]
// Generic simple dual-port RAM with registered read data.
module siol_ram #(
  parameter int Width = 8,
  parameter int Depth = 32,
  parameter int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

[rtl/siol_front.sv]
// Front part: accepts input transactions, classifies them and queues them for the back part.
module siol_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  siol_item_if.sink         item_i,
  output siol_pkg::q_head_t head_o,
  input  logic              pop_i
);
  import siol_pkg::*;

  item_t      ent_q [2];
  logic       wptr_q, wptr_d, rptr_q, rptr_d;
  logic [1:0] cnt_q, cnt_d;
  item_t      cls_item;
  logic       push;

  always_comb begin
    cls_item.key = {item_i.cylinder, item_i.head};
    cls_item.sid = item_i.sec_num;
    cls_item.fb  = item_i.fallback_position;
    unique case (item_i.operation)
      OpHeader: cls_item.cls = CLS_HEADER;
      OpFinish: cls_item.cls = CLS_FINISH;
      OpLookup: cls_item.cls = CLS_LOOKUP;
      default:  cls_item.cls = CLS_IGNORE;
    endcase
  end

  assign item_i.ready = (cnt_q != 2'd2);
  assign push         = item_i.valid && item_i.ready;
  assign head_o.valid = (cnt_q != 2'd0);
  assign head_o.item  = ent_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q ^ push;
    rptr_d = rptr_q ^ pop_i;
    cnt_d  = cnt_q + {1'b0, push} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_q[wptr_q] <= cls_item;
    end
  end

endmodule

[rtl/siol_back.sv]
// Back part: track search, pass recording, merge sequencer, lookup and result register.
module siol_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  siol_pkg::cfg_wr_t cfg_i,
  input  siol_pkg::q_head_t head_i,
  output logic              pop_o,
  siol_result_if.source     res_o
);
  import siol_pkg::*;

  state_e state_q, state_d, ret_q, ret_d;

  logic [IdW-1:0]   fsn_q;
  logic [SptW-1:0]  spt_q;
  logic [SptW-1:0]  eff_spt;

  logic [TotW-1:0]  total_q, total_d;
  logic             active_q, active_d;
  logic [CntW-1:0]  plen_q, plen_d;
  logic [MaxSectors-1:0] seen_q, seen_d;
  logic [SlotW-1:0] ptrack_q, ptrack_d;
  logic [IdW-1:0]   porder_q [MaxSectors];
  logic [IdW-1:0]   porder_d [MaxSectors];
  logic             ovld_q, ovld_d;

  cls_e             cls_q, cls_d;
  logic [KeyW-1:0]  key_q, key_d;
  logic [IdW-1:0]   sid_q, sid_d, fb_q, fb_d;
  logic [SlotW-1:0] slot_q, slot_d, rslot_q, rslot_d;
  logic [IdW-1:0]   pos_q, pos_d;
  logic             found_q, found_d, merge_q, merge_d;
  logic [1:0]       outc_q, outc_d;
  logic [IdW-1:0]   rowbuf_q [MaxSectors];
  logic [IdW-1:0]   rowbuf_d [MaxSectors];
  logic [CntW-1:0]  bcnt_q, bcnt_d, cursor_q, cursor_d, ld_q, ld_d;
  logic [SecW-1:0]  jj_q, jj_d, ii_q, ii_d, besti_q, besti_d, wb_q, wb_d;
  logic [TotW-1:0]  fa_q, fa_d;
  logic             fv_q, fv_d;
  logic [SlotW-1:0] fidx_q, fidx_d;
  logic [SlotW-1:0] oslot_q;
  logic [IdW-1:0]   opos_q;
  logic             ofound_q;
  logic [1:0]       outc_o_q;

  // RAM ports
  logic             key_we, key_re, len_we, len_re, row_we, row_re;
  logic [SlotW-1:0] key_waddr, key_raddr, len_waddr, len_raddr;
  logic [KeyW-1:0]  key_rdata;
  logic [CntW-1:0]  len_wdata, len_rdata;
  logic [RowAW-1:0] row_waddr, row_raddr;
  logic [IdW-1:0]   row_wdata, row_rdata;

  // Compare network
  logic             find_hit, find_miss, out_range, need_merge;
  logic [IdW-1:0]   rel;
  logic             best_m, lk_f, ins_hit, ins_full, ins_last;
  logic [SecW-1:0]  best_mi, lk_pos, ins_hk;
  logic [CntW-1:0]  rot_sum, rot_idx;
  logic [IdW-1:0]   ins_id;
  logic             emit;

  assign eff_spt = (spt_q == '0) ? SptW'(1) :
                   (spt_q > SptW'(MaxSectors)) ? SptW'(MaxSectors) : spt_q;

  siol_ram #(.Width(KeyW), .Depth(MaxTracks)) u_keys (
    .clk_i, .we_i(key_we), .waddr_i(key_waddr), .wdata_i(key_q),
    .re_i(key_re), .raddr_i(key_raddr), .rdata_o(key_rdata));

  siol_ram #(.Width(CntW), .Depth(MaxTracks)) u_len (
    .clk_i, .we_i(len_we), .waddr_i(len_waddr), .wdata_i(len_wdata),
    .re_i(len_re), .raddr_i(len_raddr), .rdata_o(len_rdata));

  siol_ram #(.Width(IdW), .Depth(MaxTracks * MaxSectors)) u_rows (
    .clk_i, .we_i(row_we), .waddr_i(row_waddr), .wdata_i(row_wdata),
    .re_i(row_re), .raddr_i(row_raddr), .rdata_o(row_rdata));

  always_comb begin
    find_hit   = fv_q && (key_rdata == key_q);
    find_miss  = !fv_q && (fa_q >= total_q);
    rel        = sid_q - fsn_q;
    out_range  = (sid_q < fsn_q) || (rel >= IdW'(eff_spt));
    need_merge = active_q && (ptrack_q != slot_q);

    best_m  = 1'b0;
    best_mi = '0;
    lk_f    = 1'b0;
    lk_pos  = '0;
    for (int i = 0; i < MaxSectors; i++) begin
      if (!best_m && (i < int'(plen_q)) && (porder_q[i] == rowbuf_q[jj_q])) begin
        best_m  = 1'b1;
        best_mi = SecW'(i);
      end
      if (!lk_f && (i < int'(bcnt_q)) && (rowbuf_q[i] == sid_q)) begin
        lk_f   = 1'b1;
        lk_pos = SecW'(i);
      end
    end

    rot_sum = {1'b0, besti_q} + {1'b0, ii_q};
    rot_idx = (rot_sum >= plen_q) ? rot_sum - plen_q : rot_sum;
    ins_id  = porder_q[rot_idx[SecW-1:0]];
    ins_hit = 1'b0;
    ins_hk  = '0;
    for (int k = 0; k < MaxSectors; k++) begin
      if (!ins_hit && (k >= int'(cursor_q)) && (k < int'(bcnt_q)) &&
          (rowbuf_q[k] == ins_id)) begin
        ins_hit = 1'b1;
        ins_hk  = SecW'(k);
      end
    end
    ins_full = (bcnt_q >= CntW'(eff_spt));
    ins_last = (({1'b0, ii_q} + CntW'(1)) == plen_q);
    emit     = !ovld_q || res_o.ready;
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (head_i.valid) begin
          unique case (head_i.item.cls)
            CLS_IGNORE: state_d = S_RESP;
            CLS_FINISH: state_d = active_q ? S_MLEN : S_RESP;
            default:    state_d = S_FIND;
          endcase
        end
      end
      S_FIND: begin
        if (find_hit) begin
          state_d = (cls_q == CLS_HEADER) ? S_RANGE : S_LLEN;
        end else if (find_miss) begin
          if (cls_q == CLS_HEADER) begin
            state_d = (total_q >= TotW'(MaxTracks)) ? S_RESP : S_RANGE;
          end else begin
            state_d = S_RESP;
          end
        end
      end
      S_RANGE: state_d = out_range ? S_RESP : (need_merge ? S_MLEN : S_REC);
      S_REC:   state_d = S_RESP;
      S_MLEN:  state_d = S_MCNT;
      S_MCNT:  state_d = (len_rdata == '0) ? S_WB : S_LOAD;
      S_LOAD: begin
        if (ld_q == CntW'(MaxSectors)) begin
          state_d = merge_q ? S_BEST : S_LSRCH;
        end
      end
      S_BEST: begin
        if (best_m || (({1'b0, jj_q} + CntW'(1)) >= bcnt_q)) begin
          state_d = S_INS;
        end
      end
      S_INS: begin
        if ((!ins_hit && ins_full) || ins_last) begin
          state_d = S_WB;
        end
      end
      S_WB: begin
        if (wb_q == SecW'(MaxSectors - 1)) begin
          state_d = ret_q;
        end
      end
      S_LLEN:  state_d = S_LCNT;
      S_LCNT:  state_d = S_LOAD;
      S_LSRCH: state_d = S_RESP;
      S_RESP:  state_d = emit ? S_IDLE : S_RESP;
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath and memory controls
  always_comb begin
    total_d  = total_q;
    active_d = active_q;
    plen_d   = plen_q;
    seen_d   = seen_q;
    ptrack_d = ptrack_q;
    porder_d = porder_q;
    ovld_d   = ovld_q && !res_o.ready;
    cls_d    = cls_q;
    key_d    = key_q;
    sid_d    = sid_q;
    fb_d     = fb_q;
    slot_d   = slot_q;
    rslot_d  = rslot_q;
    pos_d    = pos_q;
    found_d  = found_q;
    merge_d  = merge_q;
    outc_d   = outc_q;
    ret_d    = ret_q;
    rowbuf_d = rowbuf_q;
    bcnt_d   = bcnt_q;
    cursor_d = cursor_q;
    ld_d     = ld_q;
    jj_d     = jj_q;
    ii_d     = ii_q;
    besti_d  = besti_q;
    wb_d     = wb_q;
    fa_d     = fa_q;
    fv_d     = 1'b0;
    fidx_d   = fidx_q;
    pop_o    = 1'b0;

    key_we    = 1'b0;
    key_waddr = total_q[SlotW-1:0];
    key_re    = 1'b0;
    key_raddr = fa_q[SlotW-1:0];
    len_we    = 1'b0;
    len_waddr = total_q[SlotW-1:0];
    len_wdata = '0;
    len_re    = 1'b0;
    len_raddr = ptrack_q;
    row_we    = 1'b0;
    row_waddr = {rslot_q, wb_q};
    row_wdata = rowbuf_q[wb_q];
    row_re    = 1'b0;
    row_raddr = {rslot_q, ld_q[SecW-1:0]};

    unique case (state_q)
      S_IDLE: begin
        if (head_i.valid) begin
          pop_o   = 1'b1;
          cls_d   = head_i.item.cls;
          key_d   = head_i.item.key;
          sid_d   = head_i.item.sid;
          fb_d    = head_i.item.fb;
          slot_d  = '0;
          pos_d   = '0;
          found_d = 1'b0;
          outc_d  = OutDone;
          fa_d    = '0;
          merge_d = 1'b1;
          rslot_d = ptrack_q;
          ret_d   = S_RESP;
          // A finish reports the merged track only when a pass is open.
          if ((head_i.item.cls == CLS_FINISH) && active_q) begin
            slot_d = ptrack_q;
          end
        end
      end
      S_FIND: begin
        if (fa_q < total_q) begin
          key_re = 1'b1;
          fa_d   = fa_q + TotW'(1);
          fv_d   = 1'b1;
          fidx_d = fa_q[SlotW-1:0];
        end
        if (find_hit) begin
          slot_d = fidx_q;
        end else if (find_miss) begin
          if (cls_q == CLS_HEADER) begin
            if (total_q >= TotW'(MaxTracks)) begin
              outc_d = OutFull;
            end else begin
              slot_d  = total_q[SlotW-1:0];
              key_we  = 1'b1;
              len_we  = 1'b1;
              total_d = total_q + TotW'(1);
            end
          end else begin
            pos_d = fb_q;
          end
        end
      end
      S_RANGE: begin
        if (out_range) begin
          outc_d = OutRange;
        end else begin
          merge_d = 1'b1;
          rslot_d = ptrack_q;
          ret_d   = S_REC;
        end
      end
      S_REC: begin
        if (!active_q) begin
          ptrack_d = slot_q;
          active_d = 1'b1;
        end
        if (!seen_q[rel[SecW-1:0]] && (plen_q < CntW'(MaxSectors))) begin
          seen_d[rel[SecW-1:0]]      = 1'b1;
          porder_d[plen_q[SecW-1:0]] = sid_q;
          plen_d                     = plen_q + CntW'(1);
        end
      end
      S_MLEN: begin
        len_re = 1'b1;
      end
      S_MCNT: begin
        ld_d = '0;
        wb_d = '0;
        if (len_rdata == '0) begin
          rowbuf_d = porder_q;
          bcnt_d   = plen_q;
        end else begin
          bcnt_d = len_rdata;
        end
      end
      S_LOAD: begin
        if (ld_q < CntW'(MaxSectors)) begin
          row_re = 1'b1;
        end
        if (ld_q != '0) begin
          rowbuf_d[SecW'(ld_q - CntW'(1))] = row_rdata;
        end
        ld_d = ld_q + CntW'(1);
        jj_d = '0;
      end
      S_BEST: begin
        ii_d = '0;
        if (best_m) begin
          besti_d  = best_mi;
          cursor_d = {1'b0, jj_q};
        end else begin
          besti_d  = '0;
          cursor_d = '0;
          jj_d     = jj_q + SecW'(1);
        end
      end
      S_INS: begin
        wb_d = '0;
        ii_d = ii_q + SecW'(1);
        if (ins_hit) begin
          cursor_d = {1'b0, ins_hk} + CntW'(1);
        end else if (!ins_full) begin
          // Open a gap at the cursor and place the new id there.
          for (int k = 1; k < MaxSectors; k++) begin
            if (k > int'(cursor_q)) begin
              rowbuf_d[k] = rowbuf_q[k-1];
            end
          end
          rowbuf_d[cursor_q[SecW-1:0]] = ins_id;
          bcnt_d   = bcnt_q + CntW'(1);
          cursor_d = cursor_q + CntW'(1);
        end
      end
      S_WB: begin
        row_we = 1'b1;
        wb_d   = wb_q + SecW'(1);
        if (wb_q == SecW'(MaxSectors - 1)) begin
          len_we    = 1'b1;
          len_waddr = rslot_q;
          len_wdata = bcnt_q;
          seen_d    = '0;
          plen_d    = '0;
          active_d  = 1'b0;
        end
      end
      S_LLEN: begin
        len_re    = 1'b1;
        len_raddr = slot_q;
      end
      S_LCNT: begin
        bcnt_d  = len_rdata;
        rslot_d = slot_q;
        merge_d = 1'b0;
        ld_d    = '0;
      end
      S_LSRCH: begin
        found_d = lk_f;
        pos_d   = lk_f ? IdW'(lk_pos) : fb_q;
      end
      S_RESP: begin
        if (emit) begin
          ovld_d = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      fsn_q    <= '0;
      spt_q    <= SptReset;
      total_q  <= '0;
      active_q <= 1'b0;
      plen_q   <= '0;
      seen_q   <= '0;
      ptrack_q <= '0;
      ovld_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      total_q  <= total_d;
      active_q <= active_d;
      plen_q   <= plen_d;
      seen_q   <= seen_d;
      ptrack_q <= ptrack_d;
      ovld_q   <= ovld_d;
      if (cfg_i.we) begin
        unique case (cfg_reg_e'(cfg_i.idx))
          CFG_FIRST_SECTOR: fsn_q <= cfg_i.data;
          CFG_TRACK_LEN:    spt_q <= cfg_i.data[SptW-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    porder_q <= porder_d;
    cls_q    <= cls_d;
    key_q    <= key_d;
    sid_q    <= sid_d;
    fb_q     <= fb_d;
    slot_q   <= slot_d;
    rslot_q  <= rslot_d;
    pos_q    <= pos_d;
    found_q  <= found_d;
    merge_q  <= merge_d;
    outc_q   <= outc_d;
    ret_q    <= ret_d;
    rowbuf_q <= rowbuf_d;
    bcnt_q   <= bcnt_d;
    cursor_q <= cursor_d;
    ld_q     <= ld_d;
    jj_q     <= jj_d;
    ii_q     <= ii_d;
    besti_q  <= besti_d;
    wb_q     <= wb_d;
    fa_q     <= fa_d;
    fv_q     <= fv_d;
    fidx_q   <= fidx_d;
    if (state_q == S_RESP && emit) begin
      oslot_q  <= slot_q;
      opos_q   <= pos_q;
      ofound_q <= found_q;
      outc_o_q <= outc_q;
    end
  end

  assign res_o.valid      = ovld_q;
  assign res_o.track_slot = oslot_q;
  assign res_o.position   = opos_q;
  assign res_o.found      = ofound_q;
  assign res_o.outcome    = outc_o_q;

`ifndef SYNTHESIS
  a_total_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= TotW'(MaxTracks))
    else $error("track count exceeds table size");

  a_idle_pass_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !active_q |-> (plen_q == '0))
    else $error("inactive pass holds entries");

  a_seen_matches_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(seen_q) == int'(plen_q))
    else $error("seen flags disagree with pass length");

  a_cursor_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_INS) |-> ((cursor_q <= bcnt_q) && (bcnt_q <= CntW'(MaxSectors))))
    else $error("merge cursor beyond learned length");
`endif

endmodule

[rtl/sector_interleave_order_learner_unit.sv]
// Top level of the sector interleave order learner.
//
//  Channel   Direction  Handshake     Content
//  item_i    in         valid/ready   operation, cylinder, head, sec_num, fallback_position
//  result_o  out        valid/ready   track_slot, position, found, outcome
//  cfg_*     in         write enable  first sector id (0), sectors in use per track (1)
//
// A header or lookup searches the track table one entry per cycle. A merge writes the
// pass order straight back for a track with no learned order yet; else it does a row
// load, a match scan, up to one insert step per pass entry and a 32-entry write back.
// A lookup of a known track adds a row load and a search of the loaded row. The longest
// transaction is a header that finds its track last in a full table and forces a merge.
// Reset clears the track count and the pass state; the memories need no clearing pass.
// A two-entry queue in front takes transactions while a result waits in its register.
module sector_interleave_order_learner_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [siol_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [siol_pkg::CfgW-1:0]     cfg_data_i,
  siol_item_if.sink                     item_i,
  siol_result_if.source                 result_o
);
  import siol_pkg::*;

  // Queue head from the front part and the pop strobe from the back part.
  q_head_t head;
  logic    pop;
  cfg_wr_t cfg;

  // The configuration write is bundled and handed to the back part, which owns the registers.
  assign cfg.we   = cfg_we_i;
  assign cfg.idx  = cfg_idx_i;
  assign cfg.data = cfg_data_i;

  // The front part classifies each transaction by its operation code and queues it.
  siol_front u_front (
    .clk_i,
    .rst_ni,
    .item_i,
    .head_o (head),
    .pop_i  (pop)
  );

  // The back part runs one queued transaction at a time and holds the result register.
  siol_back u_back (
    .clk_i,
    .rst_ni,
    .cfg_i  (cfg),
    .head_i (head),
    .pop_o  (pop),
    .res_o  (result_o)
  );

endmodule
